### src/xlsr_pkg.sv
// Shared types and operation codes for the 16-bit logic, shift and rotate ALU.
// No dependencies; imported by the core and the top level.
`timescale 1ns / 1ps

package xlsr_pkg;

  // Operation codes
  localparam logic [3:0] FUNC_AND  = 4'd0;
  localparam logic [3:0] FUNC_OR   = 4'd1;
  localparam logic [3:0] FUNC_XOR  = 4'd2;
  localparam logic [3:0] FUNC_TEST = 4'd3;
  localparam logic [3:0] FUNC_NOT  = 4'd4;
  localparam logic [3:0] FUNC_SHL  = 4'd5;
  localparam logic [3:0] FUNC_SHR  = 4'd6;
  localparam logic [3:0] FUNC_SAR  = 4'd7;
  localparam logic [3:0] FUNC_ROL  = 4'd8;
  localparam logic [3:0] FUNC_ROR  = 4'd9;
  localparam logic [3:0] FUNC_RCL  = 4'd10;
  localparam logic [3:0] FUNC_RCR  = 4'd11;

  // Operand widths in bits
  localparam logic [7:0] WORD_BITS = 8'd16;
  localparam logic [7:0] BYTE_BITS = 8'd8;

  // One input item
  typedef struct packed {
    logic [3:0]  func;
    logic        word_size;
    logic [15:0] dest_value;
    logic [15:0] src_value;
    logic        carry_in;
  } alu_item_t;

  // One result item
  typedef struct packed {
    logic [15:0] result;
    logic        write_result;
    logic        carry_flag;
    logic        overflow_flag;
    logic        carry_overflow_valid;
    logic        sign_flag;
    logic        zero_flag;
    logic        parity_flag;
    logic        sign_zero_parity_valid;
  } alu_result_t;

endpackage

### src/xlsr_core.sv
// Combinational datapath: logic ops, barrel shifts, rotates and flag generation.
// Depends on xlsr_pkg for the item types and operation codes.
`timescale 1ns / 1ps

module xlsr_core
  import xlsr_pkg::*;
(
  input  alu_item_t   item,
  output alu_result_t res
);

  // Reciprocal constants for count mod 17 and mod 9
  localparam logic [15:0] RECIP17 = 16'd241;
  localparam logic [16:0] RECIP9  = 17'd455;

  logic        is_word;
  logic [15:0] mask;
  logic [15:0] d;
  logic [15:0] s;
  logic [7:0]  cnt;
  logic [7:0]  width;
  logic        cnt_over;

  logic [16:0] shl_x;
  logic        shl_cf;
  logic [16:0] shr_y;
  logic [15:0] se;
  logic [4:0]  sar_cc;
  logic [16:0] sar_y;

  logic [31:0] rol16_x;
  logic [15:0] rol8_x;
  logic [31:0] ror16_x;
  logic [15:0] ror8_x;
  logic [15:0] rol_r;
  logic [15:0] ror_r;

  logic [15:0] p17;
  logic [3:0]  q17;
  logic [8:0]  rem17_raw;
  logic [4:0]  e17;
  logic [16:0] p9;
  logic [4:0]  q9;
  logic [8:0]  rem9_raw;
  logic [3:0]  e9;
  logic [16:0] x17;
  logic [8:0]  x9;
  logic [33:0] rcl17_x;
  logic [33:0] rcr17_x;
  logic [17:0] rcl9_x;
  logic [17:0] rcr9_x;
  logic [15:0] rcl_r;
  logic [15:0] rcr_r;
  logic        rcl_cf;
  logic        rcr_cf;

  logic [15:0] r;
  logic        wr;
  logic        cf;
  logic        of;
  logic        cov;
  logic        szpv;
  logic        r_msb;
  logic        r_msb2;

  // Operand masking
  assign is_word  = item.word_size;
  assign mask     = is_word ? 16'hFFFF : 16'h00FF;
  assign d        = item.dest_value & mask;
  assign s        = item.src_value & mask;
  assign cnt      = item.src_value[7:0];
  assign width    = is_word ? WORD_BITS : BYTE_BITS;
  assign cnt_over = cnt > width;

  // Shifts; counts above the width are handled in the select below for SHL and SHR, and saturated in sar_cc for SAR
  assign shl_x  = {1'b0, d} << cnt[4:0];
  assign shl_cf = is_word ? shl_x[16] : shl_x[8];
  assign shr_y  = {d, 1'b0} >> cnt[4:0];
  assign se     = is_word ? d : {{8{d[7]}}, d[7:0]};
  assign sar_cc = cnt_over ? width[4:0] : cnt[4:0];
  assign sar_y  = 17'($signed({se, 1'b0}) >>> sar_cc);

  // Plain rotates, count mod width is a mask
  assign rol16_x = {d, d} << cnt[3:0];
  assign rol8_x  = {d[7:0], d[7:0]} << cnt[2:0];
  assign ror16_x = {d, d} >> cnt[3:0];
  assign ror8_x  = {d[7:0], d[7:0]} >> cnt[2:0];
  assign rol_r   = is_word ? rol16_x[31:16] : {8'h00, rol8_x[15:8]};
  assign ror_r   = is_word ? ror16_x[15:0] : {8'h00, ror8_x[7:0]};

  // Count mod 17 and mod 9 by reciprocal multiply with one correction step
  assign p17       = 16'(cnt) * RECIP17;
  assign q17       = p17[15:12];
  assign rem17_raw = 9'(cnt) - 9'({5'b0, q17}) * 9'd17;
  assign e17       = (rem17_raw >= 9'd17) ? 5'(rem17_raw - 9'd17) : rem17_raw[4:0];
  assign p9        = 17'(cnt) * RECIP9;
  assign q9        = p9[16:12];
  assign rem9_raw  = 9'(cnt) - 9'({4'b0, q9}) * 9'd9;
  assign e9        = (rem9_raw >= 9'd9) ? 4'(rem9_raw - 9'd9) : rem9_raw[3:0];

  // Rotates through carry over width+1 bits
  assign x17     = {item.carry_in, d};
  assign x9      = {item.carry_in, d[7:0]};
  assign rcl17_x = {x17, x17} << e17;
  assign rcr17_x = {x17, x17} >> e17;
  assign rcl9_x  = {x9, x9} << e9;
  assign rcr9_x  = {x9, x9} >> e9;
  assign rcl_r   = is_word ? rcl17_x[32:17] : {8'h00, rcl9_x[16:9]};
  assign rcl_cf  = is_word ? rcl17_x[33] : rcl9_x[17];
  assign rcr_r   = is_word ? rcr17_x[15:0] : {8'h00, rcr9_x[7:0]};
  assign rcr_cf  = is_word ? rcr17_x[16] : rcr9_x[8];

  // Operation select
  always_comb begin
    r    = d;
    wr   = 1'b1;
    cf   = 1'b0;
    of   = 1'b0;
    cov  = 1'b0;
    szpv = 1'b0;
    unique case (item.func)
      FUNC_AND: begin
        r    = d & s;
        cov  = 1'b1;
        szpv = 1'b1;
      end
      FUNC_OR: begin
        r    = d | s;
        cov  = 1'b1;
        szpv = 1'b1;
      end
      FUNC_XOR: begin
        r    = d ^ s;
        cov  = 1'b1;
        szpv = 1'b1;
      end
      FUNC_TEST: begin
        r    = d & s;
        cov  = 1'b1;
        szpv = 1'b1;
        wr   = 1'b0;
      end
      FUNC_NOT: begin
        r = ~d & mask;
      end
      FUNC_SHL: begin
        szpv = 1'b1;
        if (cnt != 8'd0) begin
          cov = 1'b1;
          if (cnt_over) begin
            r  = 16'h0000;
            cf = 1'b0;
          end else begin
            r  = shl_x[15:0] & mask;
            cf = shl_cf;
          end
          if (cnt == 8'd1) begin
            of = (is_word ? r[15] : r[7]) ^ cf;
          end
        end
      end
      FUNC_SHR: begin
        szpv = 1'b1;
        if (cnt != 8'd0) begin
          cov = 1'b1;
          if (cnt_over) begin
            r  = 16'h0000;
            cf = 1'b0;
          end else begin
            r  = shr_y[16:1];
            cf = shr_y[0];
          end
          if (cnt == 8'd1) begin
            of = is_word ? d[15] : d[7];
          end
        end
      end
      FUNC_SAR: begin
        szpv = 1'b1;
        if (cnt != 8'd0) begin
          cov = 1'b1;
          r   = sar_y[16:1] & mask;
          cf  = sar_y[0];
        end
      end
      FUNC_ROL: begin
        if (cnt != 8'd0) begin
          cov = 1'b1;
          r   = rol_r;
          cf  = rol_r[0];
          of  = (is_word ? rol_r[15] : rol_r[7]) ^ rol_r[0];
        end
      end
      FUNC_ROR: begin
        if (cnt != 8'd0) begin
          cov = 1'b1;
          r   = ror_r;
          cf  = is_word ? ror_r[15] : ror_r[7];
          of  = is_word ? (ror_r[15] ^ ror_r[14]) : (ror_r[7] ^ ror_r[6]);
        end
      end
      FUNC_RCL: begin
        if (cnt != 8'd0) begin
          cov = 1'b1;
          r   = rcl_r;
          cf  = rcl_cf;
          of  = (is_word ? rcl_r[15] : rcl_r[7]) ^ rcl_cf;
        end
      end
      FUNC_RCR: begin
        if (cnt != 8'd0) begin
          cov = 1'b1;
          r   = rcr_r;
          cf  = rcr_cf;
          of  = is_word ? (rcr_r[15] ^ rcr_r[14]) : (rcr_r[7] ^ rcr_r[6]);
        end
      end
      default: begin
        // unused codes pass the operand through with nothing written
        wr = 1'b0;
      end
    endcase
  end

  // Flag outputs, zeroed when not valid
  assign r_msb  = is_word ? r[15] : r[7];
  assign r_msb2 = 1'b0;

  assign res.result                 = r & mask;
  assign res.write_result           = wr;
  assign res.carry_flag             = cov & cf;
  assign res.overflow_flag          = cov & of;
  assign res.carry_overflow_valid   = cov;
  assign res.sign_flag              = szpv & (r_msb | r_msb2);
  assign res.zero_flag              = szpv & ((r & mask) == 16'h0000);
  assign res.parity_flag            = szpv & ~(^r[7:0]);
  assign res.sign_zero_parity_valid = szpv;

endmodule

### src/x86_16_logic_shift_rotate_alu_unit.sv
// 16-bit logic, shift and rotate ALU: top level with input and result registers.
// Depends on xlsr_pkg and xlsr_core.
//
// Usage:
//   Input channel (in_valid / in_ready) carries one operation per item:
//   func, word_size, dest_value, src_value, carry_in.
//   Output channel (out_valid / out_ready) carries one result item per
//   input item: result, write_result and the flags with their valid bits.
//   The item is captured in the input register at the accepting edge and
//   passes the core's combinational datapath. It is captured in the result
//   register when that register is free, and out_valid then rises.
//   Throughput is one item per cycle while out_ready stays high; the barrel
//   shifters and flag logic sit in one register-to-register path.
//   When the receiver stalls, the result register holds its item and the
//   input register keeps accepting until it too is full; in_ready then
//   drops until out_ready returns.
//   Synchronous reset (rst) empties both registers; no item is in flight
//   after reset and in_ready is high.
`timescale 1ns / 1ps

module x86_16_logic_shift_rotate_alu_unit
  import xlsr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  func,
  input  logic        word_size,
  input  logic [15:0] dest_value,
  input  logic [15:0] src_value,
  input  logic        carry_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] result,
  output logic        write_result,
  output logic        carry_flag,
  output logic        overflow_flag,
  output logic        carry_overflow_valid,
  output logic        sign_flag,
  output logic        zero_flag,
  output logic        parity_flag,
  output logic        sign_zero_parity_valid
);

  logic        stage_valid;
  alu_item_t   stage_item;
  alu_result_t core_res;
  alu_result_t res;
  logic        out_free;

  // Ready chain: each register takes a new item when empty or draining
  assign out_free = !out_valid || out_ready;
  assign in_ready = !stage_valid || out_free;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_item <= '{func:       func,
                      word_size:  word_size,
                      dest_value: dest_value,
                      src_value:  src_value,
                      carry_in:   carry_in};
    end
  end

  xlsr_core u_core (
    .item (stage_item),
    .res  (core_res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && stage_valid) begin
      res <= core_res;
    end
  end

  assign result                 = res.result;
  assign write_result           = res.write_result;
  assign carry_flag             = res.carry_flag;
  assign overflow_flag          = res.overflow_flag;
  assign carry_overflow_valid   = res.carry_overflow_valid;
  assign sign_flag              = res.sign_flag;
  assign zero_flag              = res.zero_flag;
  assign parity_flag            = res.parity_flag;
  assign sign_zero_parity_valid = res.sign_zero_parity_valid;

endmodule

### src/xlsr_checker.sv
// Port-level checks for the ALU unit, attached to the top level by bind.
// Depends only on the top level's port names.
`timescale 1ns / 1ps

module xlsr_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] result,
  input logic        zero_flag,
  input logic        carry_flag,
  input logic        overflow_flag,
  input logic        carry_overflow_valid,
  input logic        sign_zero_parity_valid
);

  // Reset leaves no item in flight
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid set after reset");

  // A stalled result item holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result))
    else $error("stalled result item changed");

  // An empty result register never blocks the input
  assert property (@(posedge clk) disable iff (rst) !out_valid |-> in_ready)
    else $error("input blocked while output empty");

  // Flag consistency on a delivered item
  assert property (@(posedge clk) disable iff (rst)
    out_valid && sign_zero_parity_valid |-> (zero_flag == (result == 16'h0000))
      && (carry_overflow_valid || (!carry_flag && !overflow_flag)))
    else $error("flags disagree with result");

endmodule

bind x86_16_logic_shift_rotate_alu_unit xlsr_checker u_xlsr_checker (
  .clk                    (clk),
  .rst                    (rst),
  .in_ready               (in_ready),
  .out_valid              (out_valid),
  .out_ready              (out_ready),
  .result                 (result),
  .zero_flag              (zero_flag),
  .carry_flag             (carry_flag),
  .overflow_flag          (overflow_flag),
  .carry_overflow_valid   (carry_overflow_valid),
  .sign_zero_parity_valid (sign_zero_parity_valid)
);

### bench/tb_x86_16_logic_shift_rotate_alu_unit.sv
// Self-checking bench for x86_16_logic_shift_rotate_alu_unit: a directed and a
// random stream of operations, with results predicted in-bench. Depends on
// xlsr_pkg and the RTL top level.
`timescale 1ns / 1ps

module tb_x86_16_logic_shift_rotate_alu_unit;
  import xlsr_pkg::*;

  localparam int RANDOM_OPS  = 1550;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_WAIT    = 12;
  localparam int DRAIN_WAIT  = 16;

  // One queued operation; hold_until_drained makes the sender wait for all results
  typedef struct {
    alu_item_t item;
    bit        hold_until_drained;
  } pending_op_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        out_ready = 1'b0;
  alu_item_t   drive_item = '0;
  logic        in_ready;
  logic        out_valid;
  alu_result_t seen;

  pending_op_t op_queue[$];
  alu_result_t expected_results[$];
  int          ops_total = 0;
  int          ops_accepted = 0;
  int          mismatch_count = 0;
  int          cycle_count = 0;
  int          gap_left = 0;
  int          stall_left = 0;
  bit          in_taken = 1'b0;
  bit          out_taken = 1'b0;
  logic        calm;

  // Periodic stretches in which neither side idles
  assign calm = (ops_accepted % 256) < 40;

  always #2 clk = ~clk;

  x86_16_logic_shift_rotate_alu_unit uut (
    .clk                    (clk),
    .rst                    (rst),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .func                   (drive_item.func),
    .word_size              (drive_item.word_size),
    .dest_value             (drive_item.dest_value),
    .src_value              (drive_item.src_value),
    .carry_in               (drive_item.carry_in),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .result                 (seen.result),
    .write_result           (seen.write_result),
    .carry_flag             (seen.carry_flag),
    .overflow_flag          (seen.overflow_flag),
    .carry_overflow_valid   (seen.carry_overflow_valid),
    .sign_flag              (seen.sign_flag),
    .zero_flag              (seen.zero_flag),
    .parity_flag            (seen.parity_flag),
    .sign_zero_parity_valid (seen.sign_zero_parity_valid)
  );

  // Expected result of one operation
  function automatic alu_result_t predict_alu(input alu_item_t op);
    alu_result_t res;
    int unsigned w, cnt, e, cc;
    logic [31:0] m, msb_mask, d, s, x, xm, se, r;
    logic        cf, of, cov, szpv, wr;
    w        = op.word_size ? 16 : 8;
    m        = op.word_size ? 32'hFFFF : 32'hFF;
    msb_mask = op.word_size ? 32'h8000 : 32'h80;
    d        = {16'h0, op.dest_value} & m;
    s        = {16'h0, op.src_value} & m;
    cnt      = {24'h0, op.src_value[7:0]};
    r = d; wr = 1'b1; cf = 1'b0; of = 1'b0; cov = 1'b0; szpv = 1'b0;
    case (op.func)
      FUNC_AND: begin
        r = d & s; cov = 1'b1; szpv = 1'b1;
      end
      FUNC_OR: begin
        r = d | s; cov = 1'b1; szpv = 1'b1;
      end
      FUNC_XOR: begin
        r = d ^ s; cov = 1'b1; szpv = 1'b1;
      end
      FUNC_TEST: begin
        r = d & s; cov = 1'b1; szpv = 1'b1; wr = 1'b0;
      end
      FUNC_NOT: begin
        r = ~d & m;
      end
      FUNC_SHL, FUNC_SHR, FUNC_SAR: begin
        // shift by zero still refreshes sign, zero and parity
        szpv = 1'b1;
        if (cnt != 0) begin
          cov = 1'b1;
          if (op.func == FUNC_SHL) begin
            if (cnt > w) begin
              r = '0; cf = 1'b0;
            end else begin
              x  = d << cnt;
              cf = x[w];
              r  = x & m;
            end
            if (cnt == 1) of = (|(r & msb_mask)) ^ cf;
          end else if (op.func == FUNC_SHR) begin
            if (cnt > w) begin
              r = '0; cf = 1'b0;
            end else begin
              cf = d[cnt-1];
              r  = d >> cnt;
            end
            if (cnt == 1) of = |(d & msb_mask);
          end else begin
            // arithmetic shift: sign fills in, count saturates at the width
            se = d[w-1] ? (d | ~m) : d;
            cc = (cnt > w) ? w : cnt;
            cf = se[cc-1];
            r  = (se >> cc) & m;
          end
        end
      end
      FUNC_ROL, FUNC_ROR: begin
        if (cnt != 0) begin
          cov = 1'b1;
          e   = cnt % w;
          if (op.func == FUNC_ROL) begin
            if (e != 0) r = ((d << e) | (d >> (w - e))) & m;
            cf = r[0];
            of = r[w-1] ^ cf;
          end else begin
            if (e != 0) r = ((d >> e) | (d << (w - e))) & m;
            cf = r[w-1];
            of = cf ^ r[w-2];
          end
        end
      end
      FUNC_RCL, FUNC_RCR: begin
        // rotate through carry over width+1 bits
        if (cnt != 0) begin
          cov  = 1'b1;
          e    = cnt % (w + 1);
          xm   = (m << 1) | 32'h1;
          x    = d;
          x[w] = op.carry_in;
          if (e != 0) begin
            if (op.func == FUNC_RCL) x = ((x << e) | (x >> (w + 1 - e))) & xm;
            else x = ((x >> e) | (x << (w + 1 - e))) & xm;
          end
          r  = x & m;
          cf = x[w];
          if (op.func == FUNC_RCL) of = r[w-1] ^ cf;
          else of = r[w-1] ^ r[w-2];
        end
      end
      default: begin
        wr = 1'b0;
      end
    endcase
    r = r & m;
    res.result                 = r[15:0];
    res.write_result           = wr;
    res.carry_flag             = cov & cf;
    res.overflow_flag          = cov & of;
    res.carry_overflow_valid   = cov;
    res.sign_flag              = szpv & (|(r & msb_mask));
    res.zero_flag              = szpv & (r == 0);
    res.parity_flag            = szpv & ~^r[7:0];
    res.sign_zero_parity_valid = szpv;
    return res;
  endfunction

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  task automatic add_op(input logic [3:0] f, input logic ws, input logic [15:0] dv,
                        input logic [15:0] sv, input logic c, input bit hold = 1'b0);
    pending_op_t p;
    p.item.func       = f;
    p.item.word_size  = ws;
    p.item.dest_value = dv;
    p.item.src_value  = sv;
    p.item.carry_in   = c;
    p.hold_until_drained = hold;
    op_queue.push_back(p);
    ops_total++;
  endtask

  // Monitor: records handshakes and checks each result against the oldest prediction
  always @(posedge clk) begin
    alu_result_t want;
    cycle_count++;
    in_taken  = 1'b0;
    out_taken = 1'b0;
    if (!rst) begin
      if (out_valid && out_ready) begin
        out_taken = 1'b1;
        if (expected_results.size() == 0) begin
          $error("result item with no pending expectation: result %h", seen.result);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("result", want.result, seen.result);
          check_field("write_result", want.write_result, seen.write_result);
          check_field("carry_flag", want.carry_flag, seen.carry_flag);
          check_field("overflow_flag", want.overflow_flag, seen.overflow_flag);
          check_field("carry_overflow_valid", want.carry_overflow_valid,
                      seen.carry_overflow_valid);
          check_field("sign_flag", want.sign_flag, seen.sign_flag);
          check_field("zero_flag", want.zero_flag, seen.zero_flag);
          check_field("parity_flag", want.parity_flag, seen.parity_flag);
          check_field("sign_zero_parity_valid", want.sign_zero_parity_valid,
                      seen.sign_zero_parity_valid);
        end
      end
      if (in_valid && in_ready) begin
        in_taken = 1'b1;
        expected_results.push_back(predict_alu(drive_item));
        ops_accepted++;
      end
    end
  end

  // Driver: presents queued items with a random gap before each
  always @(negedge clk) begin
    pending_op_t nxt;
    if (!rst && !(in_valid && !in_taken)) begin
      if (in_valid) gap_left = calm ? 0 : $urandom_range(0, MAX_WAIT);
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (op_queue.size() > 0 &&
                   !(op_queue[0].hold_until_drained && expected_results.size() != 0)) begin
        nxt = op_queue.pop_front();
        drive_item <= nxt.item;
        in_valid   <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stall before each result
  always @(negedge clk) begin
    if (!rst) begin
      if (out_taken) stall_left = calm ? 0 : $urandom_range(0, MAX_WAIT);
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("end of test: mismatches");
    $finish;
  end

  // Stimulus and end of run
  initial begin : stimulus
    logic [15:0] corner_vals[6];
    logic [3:0]  f;
    logic [15:0] dv, sv;
    logic [7:0]  cnt;
    corner_vals = '{16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h0080, 16'h007F};

    // Directed: extremes, every operation, zero counts and out-of-range counts
    add_op(FUNC_AND,  1'b1, 16'hFFFF, 16'hFFFF, 1'b0);
    add_op(FUNC_OR,   1'b0, 16'h0000, 16'h0000, 1'b1);
    add_op(FUNC_XOR,  1'b1, 16'h8000, 16'h0001, 1'b0);
    add_op(FUNC_TEST, 1'b0, 16'hABFF, 16'hCD80, 1'b1);
    add_op(FUNC_NOT,  1'b1, 16'h5A5A, 16'h0000, 1'b0);
    add_op(FUNC_NOT,  1'b0, 16'hFF00, 16'hFFFF, 1'b1);
    add_op(FUNC_SHL,  1'b1, 16'h8001, 16'hFF00, 1'b1);
    add_op(FUNC_SHL,  1'b0, 16'h00C0, 16'h0001, 1'b0);
    add_op(FUNC_SHL,  1'b1, 16'h0001, 16'h0010, 1'b0);
    add_op(FUNC_SHL,  1'b0, 16'h00FF, 16'h0009, 1'b0);
    add_op(FUNC_SHR,  1'b1, 16'h8001, 16'h0001, 1'b0);
    add_op(FUNC_SHR,  1'b0, 16'hFF80, 16'h0008, 1'b0);
    add_op(FUNC_SHR,  1'b1, 16'hFFFF, 16'h00FF, 1'b0);
    add_op(FUNC_SAR,  1'b0, 16'h0080, 16'h00C8, 1'b0);
    add_op(FUNC_SAR,  1'b1, 16'h7FFF, 16'h0014, 1'b0);
    add_op(FUNC_SAR,  1'b1, 16'h8000, 16'h0001, 1'b0);
    add_op(FUNC_ROL,  1'b0, 16'h0081, 16'hFF00, 1'b1);
    add_op(FUNC_ROL,  1'b1, 16'h8001, 16'h0010, 1'b0);
    add_op(FUNC_ROR,  1'b0, 16'h0001, 16'h0001, 1'b0);
    add_op(FUNC_ROR,  1'b1, 16'h4001, 16'h00FF, 1'b0);
    add_op(FUNC_RCL,  1'b0, 16'h00A5, 16'h0009, 1'b1);
    add_op(FUNC_RCL,  1'b1, 16'h8000, 16'h0001, 1'b1);
    add_op(FUNC_RCR,  1'b0, 16'h0001, 16'h0001, 1'b0);
    add_op(FUNC_RCR,  1'b1, 16'h1234, 16'h0011, 1'b1);
    add_op(FUNC_RCR + 4'd1, 1'b1, 16'hBEEF, 16'h0003, 1'b1);
    add_op(4'd15,     1'b0, 16'hFFFF, 16'hFFFF, 1'b1);

    // Random: mostly defined operations, counts biased toward the width
    for (int i = 0; i < RANDOM_OPS; i++) begin
      if ($urandom_range(0, 99) < 4) f = 4'($urandom_range(FUNC_RCR + 1, 15));
      else f = 4'($urandom_range(FUNC_AND, FUNC_RCR));
      dv = $urandom_range(0, 99) < 15 ? corner_vals[$urandom_range(0, 5)]
                                      : 16'($urandom);
      sv = 16'($urandom);
      if (f >= FUNC_SHL && f <= FUNC_RCR) begin
        cnt = $urandom_range(0, 99) < 60 ? 8'($urandom_range(0, 18))
                                         : 8'($urandom_range(0, 255));
        sv[7:0] = cnt;
      end else if ($urandom_range(0, 99) < 15) begin
        sv = corner_vals[$urandom_range(0, 5)];
      end
      add_op(f, 1'($urandom), dv, sv, 1'($urandom), i == 0 || i == 700 || i == 1200);
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (!(ops_accepted == ops_total && expected_results.size() == 0)) @(negedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatch_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
